// File: src/mwf_pkg.sv
// mwf_pkg: shared types and constants for the lock bank with fifo wait queues
// depends on nothing; used by mwf_lock_bank and mutex_with_fifo_waiters_unit

package mwf_pkg;

  // default sizing, used as defaults by the top level parameters
  localparam int NUM_LOCKS_DEF  = 3;
  localparam int WAIT_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF   = 8;

  // fixed port widths
  localparam int LOCK_W   = 2;
  localparam int PID_W    = 8;
  localparam int STATUS_W = 3;

  // request codes
  localparam logic ACT_WAIT   = 1'b0;
  localparam logic ACT_SIGNAL = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_FREED    = 3'd2,
    ST_HANDOFF  = 3'd3,
    ST_UNLOCKED = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  // request held in the execute stage
  typedef struct packed {
    logic              act;
    logic [LOCK_W-1:0] lock;
  } req_t;

  // one result transfer
  typedef struct packed {
    status_t           status;
    logic [LOCK_W-1:0] lock_echo;
    logic [PID_W-1:0]  holder_pid;
    logic              holder_valid;
  } res_t;

endpackage

// File: src/mwf_ram.sv
// mwf_ram: generic single write port, single read port ram with registered read
// depends on nothing

module mwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/mwf_lock_bank.sv
// mwf_lock_bank: per-lock held flag, owner and queue pointers, plus the decision
// logic of one request; depends on mwf_pkg, drives the waiter ram ports

module mwf_lock_bank #(
  parameter int NUM_LOCKS  = mwf_pkg::NUM_LOCKS_DEF,
  parameter int WAIT_DEPTH = mwf_pkg::WAIT_DEPTH_DEF,
  parameter int PID_BITS   = mwf_pkg::PID_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      ex_valid,
  input  mwf_pkg::req_t                             ex_req,
  input  logic [PID_BITS-1:0]                       ex_pid,
  input  logic [PID_BITS-1:0]                       pop_data,
  input  logic [mwf_pkg::LOCK_W-1:0]                rd_lock,
  output logic [$clog2(NUM_LOCKS*WAIT_DEPTH)-1:0]   rd_addr,
  output logic                                      wr_en,
  output logic [$clog2(NUM_LOCKS*WAIT_DEPTH)-1:0]   wr_addr,
  output logic [PID_BITS-1:0]                       wr_data,
  output mwf_pkg::res_t                             res
);

  import mwf_pkg::*;

  localparam int SLOT_W  = $clog2(WAIT_DEPTH);
  localparam int COUNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_LOCKS * WAIT_DEPTH);

  logic                held       [NUM_LOCKS];
  logic [PID_BITS-1:0] owner      [NUM_LOCKS];
  logic [SLOT_W-1:0]   head       [NUM_LOCKS];
  logic [SLOT_W-1:0]   tail       [NUM_LOCKS];
  logic [COUNT_W-1:0]  count      [NUM_LOCKS];
  logic                held_next  [NUM_LOCKS];
  logic [PID_BITS-1:0] owner_next [NUM_LOCKS];
  logic [SLOT_W-1:0]   head_next  [NUM_LOCKS];
  logic [SLOT_W-1:0]   tail_next  [NUM_LOCKS];
  logic [COUNT_W-1:0]  count_next [NUM_LOCKS];

  logic                known;
  logic                cur_held;
  logic [PID_BITS-1:0] cur_owner;
  logic [SLOT_W-1:0]   cur_head;
  logic [SLOT_W-1:0]   cur_tail;
  logic [COUNT_W-1:0]  cur_count;
  logic [ADDR_W-1:0]   cur_base;
  logic                do_acq;
  logic                do_push;
  logic                do_free;
  logic                do_pop;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // select the addressed lock
  always_comb begin
    known     = 1'b0;
    cur_held  = 1'b0;
    cur_owner = '0;
    cur_head  = '0;
    cur_tail  = '0;
    cur_count = '0;
    cur_base  = '0;
    for (int i = 0; i < NUM_LOCKS; i++) begin
      if (ex_req.lock == LOCK_W'(i)) begin
        known     = 1'b1;
        cur_held  = held[i];
        cur_owner = owner[i];
        cur_head  = head[i];
        cur_tail  = tail[i];
        cur_count = count[i];
        cur_base  = ADDR_W'(i * WAIT_DEPTH);
      end
    end
  end

  // decide the operation and build the result
  always_comb begin
    do_acq  = 1'b0;
    do_push = 1'b0;
    do_free = 1'b0;
    do_pop  = 1'b0;
    res.lock_echo    = ex_req.lock;
    res.status       = ST_UNKNOWN;
    res.holder_pid   = '0;
    res.holder_valid = 1'b0;
    if (known) begin
      if (ex_req.act == ACT_WAIT) begin
        res.holder_valid = 1'b1;
        if (!cur_held) begin
          do_acq         = 1'b1;
          res.status     = ST_ACQUIRED;
          res.holder_pid = PID_W'(ex_pid);
        end else if (cur_count == COUNT_W'(WAIT_DEPTH)) begin
          res.status     = ST_FULL;
          res.holder_pid = PID_W'(cur_owner);
        end else begin
          do_push        = 1'b1;
          res.status     = ST_BLOCKED;
          res.holder_pid = PID_W'(cur_owner);
        end
      end else begin
        if (!cur_held) begin
          res.status = ST_UNLOCKED;
        end else if (cur_count == '0) begin
          do_free    = 1'b1;
          res.status = ST_FREED;
        end else begin
          do_pop           = 1'b1;
          res.status       = ST_HANDOFF;
          res.holder_pid   = PID_W'(pop_data);
          res.holder_valid = 1'b1;
        end
      end
    end
  end

  // waiter ram write on a push
  assign wr_en   = ex_valid && do_push;
  assign wr_addr = cur_base + ADDR_W'(cur_tail);
  assign wr_data = ex_pid;

  // next state of every lock
  always_comb begin
    for (int i = 0; i < NUM_LOCKS; i++) begin
      held_next[i]  = held[i];
      owner_next[i] = owner[i];
      head_next[i]  = head[i];
      tail_next[i]  = tail[i];
      count_next[i] = count[i];
      if (ex_valid && ex_req.lock == LOCK_W'(i)) begin
        if (do_acq) begin
          held_next[i]  = 1'b1;
          owner_next[i] = ex_pid;
        end
        if (do_push) begin
          tail_next[i]  = next_slot(cur_tail);
          count_next[i] = cur_count + 1'b1;
        end
        if (do_free) begin
          held_next[i]  = 1'b0;
          owner_next[i] = '0;
        end
        if (do_pop) begin
          owner_next[i] = pop_data;
          head_next[i]  = next_slot(cur_head);
          count_next[i] = cur_count - 1'b1;
        end
      end
    end
  end

  // read address for the incoming request, from the updated head
  always_comb begin
    rd_addr = '0;
    for (int i = 0; i < NUM_LOCKS; i++) begin
      if (rd_lock == LOCK_W'(i)) begin
        rd_addr = ADDR_W'(i * WAIT_DEPTH) + ADDR_W'(head_next[i]);
      end
    end
  end

  // lock state registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LOCKS; i++) begin
      if (rst) begin
        held[i]  <= 1'b0;
        owner[i] <= '0;
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end else begin
        held[i]  <= held_next[i];
        owner[i] <= owner_next[i];
        head[i]  <= head_next[i];
        tail[i]  <= tail_next[i];
        count[i] <= count_next[i];
      end
    end
  end

  // queue occupancy never passes the depth, and waiters only exist on a held lock
  for (genvar g = 0; g < NUM_LOCKS; g++) begin : g_chk
    a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count[g] <= COUNT_W'(WAIT_DEPTH))
      else $error("wait queue count above depth");
    a_waiters_held: assert property (@(posedge clk) disable iff (rst)
      count[g] != '0 |-> held[g])
      else $error("waiters queued on a free lock");
  end

endmodule

// File: src/mutex_with_fifo_waiters_unit.sv
// mutex_with_fifo_waiters_unit: a request passes the input register and then the
// result register before the done strobe; one request accepted every cycle, busy stays low.
// the pop read is issued at acceptance from the forwarded queue head, with a
// bypass when the same slot is written at that edge.
// synchronous reset clears all locks and queues; waiter ram holds no reset.
// the receiver cannot stall: each result is shown for exactly one cycle.

module mutex_with_fifo_waiters_unit #(
  parameter int NUM_LOCKS  = mwf_pkg::NUM_LOCKS_DEF,
  parameter int WAIT_DEPTH = mwf_pkg::WAIT_DEPTH_DEF,
  parameter int PID_BITS   = mwf_pkg::PID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [mwf_pkg::LOCK_W-1:0]   lock_id,
  input  logic [mwf_pkg::PID_W-1:0]    requester_pid,
  output logic                         done,
  output logic [mwf_pkg::STATUS_W-1:0] status,
  output logic [mwf_pkg::LOCK_W-1:0]   lock_echo,
  output logic [mwf_pkg::PID_W-1:0]    holder_pid,
  output logic                         holder_valid
);

  import mwf_pkg::*;

  localparam int DEPTH  = NUM_LOCKS * WAIT_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                ex_valid;
  req_t                ex_req;
  logic [PID_BITS-1:0] ex_pid;
  logic                byp_hit;
  logic [PID_BITS-1:0] byp_data;
  logic [PID_BITS-1:0] ram_q;
  logic [PID_BITS-1:0] pop_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [PID_BITS-1:0] wr_data;
  res_t                res;
  logic                accept;

  // every request completes in one pass, so the unit never pushes back
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else begin
      ex_valid <= accept;
    end
    ex_req.act  <= action;
    ex_req.lock <= lock_id;
    ex_pid      <= PID_BITS'(requester_pid);
  end

  // same-edge write to the slot being read
  always_ff @(posedge clk) begin
    byp_hit  <= wr_en && (wr_addr == rd_addr);
    byp_data <= wr_data;
  end

  assign pop_data = byp_hit ? byp_data : ram_q;

  // waiter queues of all locks
  mwf_ram #(
    .WIDTH (PID_BITS),
    .DEPTH (DEPTH)
  ) u_waiters (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // lock state and request decision
  mwf_lock_bank #(
    .NUM_LOCKS  (NUM_LOCKS),
    .WAIT_DEPTH (WAIT_DEPTH),
    .PID_BITS   (PID_BITS)
  ) u_bank (
    .clk      (clk),
    .rst      (rst),
    .ex_valid (ex_valid),
    .ex_req   (ex_req),
    .ex_pid   (ex_pid),
    .pop_data (pop_data),
    .rd_lock  (lock_id),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ex_valid;
    end
    status       <= res.status;
    lock_echo    <= res.lock_echo;
    holder_pid   <= res.holder_pid;
    holder_valid <= res.holder_valid;
  end

  // every executed request yields exactly one result transfer, in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    ex_valid |=> done)
    else $error("executed request lost its result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !ex_valid |=> !done)
    else $error("result without a request");
  // a lock that is not held reports no holder id
  a_free_no_pid: assert property (@(posedge clk) disable iff (rst)
    done && !holder_valid |-> holder_pid == '0)
    else $error("holder id reported on a free lock");

endmodule
